// File: hdl/slkc_pkg.sv
package slkc_pkg;

  // Fixed formats: dB values are Q8.8, log2 values Q16, gains Q1.30.
  localparam int FLOOR_DB   = -15360;     // -60 dB
  localparam int RED_MAX    = 16384;      // 64 dB reduction ceiling
  localparam int LOG2_TO_DB = 394566;     // 6.0206 in Q16
  localparam int DB_TO_LOG2 = 2786635;    // 1/6.0206 in Q24
  localparam int LOG_STEPS  = 16;         // log2 fraction bits, table fraction bits

  // Register indexes
  localparam logic [7:0] REG_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_SLOPE     = 8'd1;
  localparam logic [7:0] REG_KNEE_W    = 8'd2;
  localparam logic [7:0] REG_KNEE_S    = 8'd3;
  localparam logic [7:0] REG_ATTACK    = 8'd4;
  localparam logic [7:0] REG_RELEASE   = 8'd5;
  localparam logic [7:0] REG_OUT_GAIN  = 8'd6;
  localparam logic [7:0] REG_AUTO_GAIN = 8'd7;

  // Reset values
  localparam logic [14:0] RST_THRESHOLD = 15'h6C00;  // -5120
  localparam logic [15:0] RST_SLOPE     = 16'd32768;
  localparam logic [12:0] RST_KNEE_W    = 13'd1536;
  localparam logic [14:0] RST_KNEE_S    = 15'd341;
  localparam logic [23:0] RST_ATTACK    = 24'd34914;
  localparam logic [23:0] RST_RELEASE   = 24'd3495;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_NORM,
    OP_SQR,
    OP_LVL,
    OP_DB,
    OP_ENVM,
    OP_ENVU,
    OP_KNEE1,
    OP_KNEE2,
    OP_KNEE3,
    OP_RED,
    OP_LOG2,
    OP_EXP,
    OP_IDX,
    OP_TBL,
    OP_APL,
    OP_SHL,
    OP_APR,
    OP_SHR,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] iter;
  } cmd_t;

  typedef struct packed {
    logic out_full;   // result register holds a word not yet taken
  } sts_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = '0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 64'd0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(1/2^k) in Q1.30, by repeated square roots
  function automatic logic [31:0] gain_root(input int k);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int j = 1; j <= k; j++) c = isqrt64(c << 30);
    return c[31:0];
  endfunction

endpackage

// File: hdl/slkc_ctrl.sv
module slkc_ctrl import slkc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_NORM  = 5'd1;
  localparam logic [4:0] ST_SQR   = 5'd2;
  localparam logic [4:0] ST_LVL   = 5'd3;
  localparam logic [4:0] ST_DB    = 5'd4;
  localparam logic [4:0] ST_ENVM  = 5'd5;
  localparam logic [4:0] ST_ENVU  = 5'd6;
  localparam logic [4:0] ST_KNEE1 = 5'd7;
  localparam logic [4:0] ST_KNEE2 = 5'd8;
  localparam logic [4:0] ST_KNEE3 = 5'd9;
  localparam logic [4:0] ST_RED   = 5'd10;
  localparam logic [4:0] ST_LOG2  = 5'd11;
  localparam logic [4:0] ST_EXP   = 5'd12;
  localparam logic [4:0] ST_IDX   = 5'd13;
  localparam logic [4:0] ST_TBL   = 5'd14;
  localparam logic [4:0] ST_APL   = 5'd15;
  localparam logic [4:0] ST_SHL   = 5'd16;
  localparam logic [4:0] ST_APR   = 5'd17;
  localparam logic [4:0] ST_SHR   = 5'd18;
  localparam logic [4:0] ST_DONE  = 5'd19;

  localparam logic [3:0] LAST_ITER = 4'(LOG_STEPS - 1);

  logic [4:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.iter = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd_o.op = OP_NORM;
        cnt_d    = '0;
        state_d  = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.op = OP_SQR;
        cnt_d    = 4'(cnt_q + 4'd1);
        if (cnt_q == LAST_ITER) state_d = ST_LVL;
      end
      ST_LVL: begin
        cmd_o.op = OP_LVL;
        state_d  = ST_DB;
      end
      ST_DB: begin
        cmd_o.op = OP_DB;
        state_d  = ST_ENVM;
      end
      ST_ENVM: begin
        cmd_o.op = OP_ENVM;
        state_d  = ST_ENVU;
      end
      ST_ENVU: begin
        cmd_o.op = OP_ENVU;
        state_d  = ST_KNEE1;
      end
      ST_KNEE1: begin
        cmd_o.op = OP_KNEE1;
        state_d  = ST_KNEE2;
      end
      ST_KNEE2: begin
        cmd_o.op = OP_KNEE2;
        state_d  = ST_KNEE3;
      end
      ST_KNEE3: begin
        cmd_o.op = OP_KNEE3;
        state_d  = ST_RED;
      end
      ST_RED: begin
        cmd_o.op = OP_RED;
        state_d  = ST_LOG2;
      end
      ST_LOG2: begin
        cmd_o.op = OP_LOG2;
        state_d  = ST_EXP;
      end
      ST_EXP: begin
        cmd_o.op = OP_EXP;
        state_d  = ST_IDX;
      end
      ST_IDX: begin
        cmd_o.op = OP_IDX;
        cnt_d    = '0;
        state_d  = ST_TBL;
      end
      ST_TBL: begin
        cmd_o.op = OP_TBL;
        cnt_d    = 4'(cnt_q + 4'd1);
        if (cnt_q == LAST_ITER) state_d = ST_APL;
      end
      ST_APL: begin
        cmd_o.op = OP_APL;
        state_d  = ST_SHL;
      end
      ST_SHL: begin
        cmd_o.op = OP_SHL;
        state_d  = ST_APR;
      end
      ST_APR: begin
        cmd_o.op = OP_APR;
        state_d  = ST_SHR;
      end
      ST_SHR: begin
        cmd_o.op = OP_SHR;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hdl/slkc_dp.sv
module slkc_dp import slkc_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int DB_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [((2*SAMPLE_WIDTH+37)/8)*8-1:0] m_tdata_o
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int PW    = $clog2(SAMPLE_WIDTH);
  localparam int DW    = $clog2(DB_TABLE_DEPTH);
  localparam int RW    = DW + 1;
  localparam int IPW   = 17 + DW;
  localparam int OUT_W = ((2*SAMPLE_WIDTH+37)/8)*8;

  localparam logic [4:0] TOP_BIT = 5'(SAMPLE_WIDTH - 1);

  // ceil(2^48 / D): exact floor(idx * 2^16 / D) for any idx below D
  localparam logic [40:0] RECIP =
    41'(((64'd1 << 48) + 64'(DB_TABLE_DEPTH) - 64'd1) / 64'(DB_TABLE_DEPTH));

  localparam logic [1:0] KNEE_HARD = 2'd0;
  localparam logic [1:0] KNEE_ZERO = 2'd1;
  localparam logic [1:0] KNEE_SOFT = 2'd2;

  localparam logic [31:0] ROOT_TBL [LOG_STEPS] = '{
    gain_root(1),  gain_root(2),  gain_root(3),  gain_root(4),
    gain_root(5),  gain_root(6),  gain_root(7),  gain_root(8),
    gain_root(9),  gain_root(10), gain_root(11), gain_root(12),
    gain_root(13), gain_root(14), gain_root(15), gain_root(16)
  };

  // configuration registers
  logic signed [14:0] thr_q;
  logic        [15:0] slope_q;
  logic        [12:0] kw_q;
  logic        [14:0] ks_q;
  logic        [23:0] att_q;
  logic        [23:0] rel_q;
  logic signed [13:0] og_q;
  logic               auto_on_q;

  // working registers
  logic        [W-1:0]  smp_l_q, smp_r_q;
  logic        [PW-1:0] p_q;
  logic                 zero_q;
  logic        [30:0]   x_q;
  logic        [15:0]   frac_q;
  logic        [63:0]   prod_q;
  logic signed [15:0]   lvl_q;
  logic signed [15:0]   env_q;
  logic        [30:0]   hard_q;
  logic        [1:0]    sel_q;
  logic                 xpos_q;
  logic        [27:0]   k2sq_q;
  logic        [42:0]   kk_q;
  logic signed [31:0]   autop_q;
  logic        [58:0]   soft_q;
  logic        [14:0]   red_q;
  logic signed [17:0]   total_q;
  logic        [21:0]   t_q;
  logic        [RW-1:0] rem_q;
  logic        [31:0]   mant_q;
  logic        [W-1:0]  res_l_q, res_r_q;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q;

  // ---- peak and normalize
  logic [W-1:0]  mag_l, mag_r, peak;
  logic [PW-1:0] lead;
  logic [5:0]    norm_sh;
  logic [63:0]   norm_full;

  assign mag_l = smp_l_q[W-1] ? W'(~smp_l_q + 1'b1) : smp_l_q;
  assign mag_r = smp_r_q[W-1] ? W'(~smp_r_q + 1'b1) : smp_r_q;
  assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < W; i++) begin
      if (peak[i]) lead = PW'(i);
    end
  end

  assign norm_sh   = 6'd63 - 6'(lead);
  assign norm_full = 64'(peak) << norm_sh;

  // ---- squaring step of log2
  logic [61:0] sq_full;
  logic [31:0] sq_top;
  assign sq_full = 62'(x_q) * 62'(x_q);
  assign sq_top  = sq_full[61:30];

  // ---- log2 to dB
  logic [20:0] lvl_neg;
  logic [39:0] lvl_prod;
  logic [16:0] lvl_mag;
  logic signed [15:0] lvl_db;

  assign lvl_neg  = {TOP_BIT - 5'(p_q), 16'h0000} - {5'b0, frac_q};
  assign lvl_prod = 40'(lvl_neg) * 40'(LOG2_TO_DB);
  assign lvl_mag  = 17'((prod_q[39:0] + 40'(1 << 23)) >> 24);
  always_comb begin
    if (zero_q || (lvl_mag > 17'(-FLOOR_DB))) lvl_db = 16'(FLOOR_DB);
    else lvl_db = 16'(17'd0 - lvl_mag);
  end

  // ---- envelope
  logic signed [16:0] env_diff;
  logic        [23:0] env_coeff;
  logic signed [41:0] env_prod;
  logic signed [41:0] env_p;
  logic        [41:0] env_pm;
  logic        [17:0] env_rnd;
  logic signed [18:0] env_sum;
  logic signed [15:0] env_new;

  assign env_diff  = 17'(lvl_q) - 17'(env_q);
  assign env_coeff = (lvl_q > env_q) ? att_q : rel_q;
  assign env_prod  = env_diff * $signed({1'b0, env_coeff});
  assign env_p     = $signed(prod_q[41:0]);
  assign env_pm    = env_p[41] ? 42'(-env_p) : 42'(env_p);
  assign env_rnd   = 18'((env_pm + 42'(1 << 23)) >> 24);
  assign env_sum   = env_p[41] ? 19'(env_q) - 19'(env_rnd) : 19'(env_q) + 19'(env_rnd);
  always_comb begin
    if (env_sum < FLOOR_DB) env_new = 16'(FLOOR_DB);
    else if (env_sum > 0) env_new = '0;
    else env_new = env_sum[15:0];
  end

  // ---- gain computer
  logic signed [16:0] kx;
  logic signed [17:0] kx2, kw_s, k2_s;
  logic        [1:0]  knee_sel;
  logic        [31:0] hard_p;
  logic        [27:0] k2sq;

  assign kx   = 17'(env_q) - 17'(thr_q);
  assign kx2  = {kx, 1'b0};
  assign kw_s = $signed({5'b0, kw_q});
  assign k2_s = kx2 + kw_s;
  always_comb begin
    if ((kw_q == 13'd0) || (kx2 > kw_s)) knee_sel = KNEE_HARD;
    else if (k2_s < 0) knee_sel = KNEE_ZERO;
    else knee_sel = KNEE_SOFT;
  end
  assign hard_p = 32'(kx[15:0]) * 32'(slope_q);
  assign k2sq   = 28'(k2_s[13:0]) * 28'(k2_s[13:0]);

  logic        [42:0] kk;
  logic signed [31:0] autop;
  logic        [58:0] soft_p;
  assign kk     = 43'(k2sq_q) * 43'(ks_q);
  assign autop  = thr_q * $signed({1'b0, slope_q});
  assign soft_p = 59'(kk_q) * 59'(slope_q);

  // ---- reduction and makeup
  logic        [15:0] hard_r;
  logic        [21:0] soft_r;
  logic        [21:0] red_raw;
  logic        [14:0] red_sat;
  logic        [31:0] auto_m;
  logic        [15:0] auto_r;
  logic signed [17:0] auto_term;
  logic signed [17:0] total;

  assign hard_r = 16'((32'(hard_q) + 32'h0000_8000) >> 16);
  assign soft_r = 22'((60'(soft_q) + 60'(64'd1 << 37)) >> 38);
  always_comb begin
    case (sel_q)
      KNEE_HARD: red_raw = xpos_q ? 22'(hard_r) : '0;
      KNEE_SOFT: red_raw = soft_r;
      default:   red_raw = '0;
    endcase
  end
  assign red_sat = (red_raw > 22'(RED_MAX)) ? 15'(RED_MAX) : red_raw[14:0];
  assign auto_m  = autop_q[31] ? 32'(-autop_q) : 32'(autop_q);
  assign auto_r  = 16'((33'(auto_m) + 33'(1 << 16)) >> 17);
  always_comb begin
    if (!auto_on_q) auto_term = '0;
    else if (autop_q[31]) auto_term = 18'(auto_r);
    else auto_term = 18'd0 - 18'(auto_r);
  end
  assign total = 18'(og_q) - 18'(red_sat) + auto_term;

  // ---- dB to log2, split into shift and fraction
  logic signed [40:0] lg_prod;
  logic signed [40:0] lg_p;
  logic        [40:0] lg_m;
  logic        [24:0] lg_r;
  logic signed [26:0] t_s;

  assign lg_prod = total_q * $signed(23'(DB_TO_LOG2));
  assign lg_p    = $signed(prod_q[40:0]);
  assign lg_m    = lg_p[40] ? 41'(-lg_p) : 41'(lg_p);
  assign lg_r    = 25'((42'(lg_m) + 42'(1 << 15)) >> 16);
  assign t_s     = lg_p[40] ? 27'(32 << 16) - 27'(lg_r) : 27'(32 << 16) + 27'(lg_r);

  // ---- fraction to table index, its 16-bit table fraction by reciprocal,
  //      then 2^f by serial root products, one fraction bit per step
  logic [IPW-1:0] idx_prod;
  logic [63:0]    recip_prod;
  logic [15:0]    tbl_f;
  logic           qbit;
  logic [63:0]    root_prod;

  assign idx_prod   = IPW'(t_q[15:0]) * IPW'(DB_TABLE_DEPTH);
  assign recip_prod = 64'(rem_q) * 64'(RECIP);
  assign tbl_f      = recip_prod[47:32];
  assign qbit       = tbl_f[~cmd_i.iter];
  assign root_prod  = 64'(mant_q) * 64'(ROOT_TBL[cmd_i.iter]);

  // ---- apply gain
  logic [W-1:0] ap_mag;
  logic [63:0]  ap_prod;
  logic [6:0]   sh;
  logic [64:0]  sh_sum, sh_val, lim;
  logic         sh_neg;
  logic [W-1:0] r_sat, sh_res;

  assign ap_mag  = (cmd_i.op == OP_APL) ? mag_l : mag_r;
  assign ap_prod = 64'(ap_mag) * 64'(mant_q);
  // integer part of log2 gain stays at 42 or below, so this is a right shift of 20 or more
  assign sh      = 7'd62 - 7'(t_q[21:16]);
  assign sh_sum  = 65'(prod_q) + (65'd1 << (sh - 7'd1));
  assign sh_val  = sh_sum >> sh;
  assign sh_neg  = (cmd_i.op == OP_SHL) ? smp_l_q[W-1] : smp_r_q[W-1];
  assign lim     = sh_neg ? (65'd1 << (W - 1)) : ((65'd1 << (W - 1)) - 65'd1);
  assign r_sat   = (sh_val > lim) ? lim[W-1:0] : sh_val[W-1:0];
  assign sh_res  = sh_neg ? W'(~r_sat + 1'b1) : r_sat;

  // ---- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= RST_THRESHOLD;
      slope_q   <= RST_SLOPE;
      kw_q      <= RST_KNEE_W;
      ks_q      <= RST_KNEE_S;
      att_q     <= RST_ATTACK;
      rel_q     <= RST_RELEASE;
      og_q      <= '0;
      auto_on_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: thr_q     <= cfg_data_i[14:0];
        REG_SLOPE:     slope_q   <= cfg_data_i[15:0];
        REG_KNEE_W:    kw_q      <= cfg_data_i[12:0];
        REG_KNEE_S:    ks_q      <= cfg_data_i[14:0];
        REG_ATTACK:    att_q     <= cfg_data_i;
        REG_RELEASE:   rel_q     <= cfg_data_i;
        REG_OUT_GAIN:  og_q      <= cfg_data_i[13:0];
        REG_AUTO_GAIN: auto_on_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---- state: envelope and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= 16'(FLOOR_DB);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_ENVU) env_q <= env_new;
      if (cmd_i.op == OP_OUT) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  // ---- payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        smp_l_q <= s_tdata_i[W-1:0];
        smp_r_q <= s_tdata_i[2*W-1:W];
      end
      OP_NORM: begin
        p_q    <= lead;
        zero_q <= (peak == '0);
        x_q    <= norm_full[63:33];
        frac_q <= '0;
      end
      OP_SQR: begin
        x_q    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        frac_q <= {frac_q[14:0], sq_top[31]};
      end
      OP_LVL:  prod_q <= 64'(lvl_prod);
      OP_DB:   lvl_q  <= lvl_db;
      OP_ENVM: prod_q <= 64'(env_prod);
      OP_KNEE1: begin
        sel_q  <= knee_sel;
        xpos_q <= (kx > 0);
        hard_q <= hard_p[30:0];
        k2sq_q <= k2sq;
      end
      OP_KNEE2: begin
        kk_q    <= kk;
        autop_q <= autop;
      end
      OP_KNEE3: soft_q <= soft_p;
      OP_RED: begin
        red_q   <= red_sat;
        total_q <= total;
      end
      OP_LOG2: prod_q <= 64'(lg_prod);
      OP_EXP:  t_q    <= t_s[26] ? '0 : t_s[21:0];
      OP_IDX: begin
        rem_q  <= idx_prod[16 +: RW];
        mant_q <= 32'd1 << 30;
      end
      OP_TBL: begin
        if (qbit) mant_q <= root_prod[61:30];
      end
      OP_APL, OP_APR: prod_q <= ap_prod;
      OP_SHL: res_l_q <= sh_res;
      OP_SHR: res_r_q <= sh_res;
      OP_OUT: out_data_q <= OUT_W'({env_q[14:0], red_q, res_r_q, res_l_q});
      default: ;
    endcase
  end

  assign sts_o.out_full = out_valid_q & ~m_tready_i;
  assign m_tvalid_o     = out_valid_q;
  assign m_tdata_o      = out_data_q;

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (env_q >= FLOOR_DB) && (env_q <= 0))
    else $error("envelope left its range");

  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[2*W +: 15] <= 15'(RED_MAX)))
    else $error("reduction above ceiling");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == OP_OUT))
    else $error("result word raised without a store");

endmodule

// File: hdl/stereo_linked_soft_knee_compressor_top.sv
// Stereo-linked soft-knee compressor.
// Input channel s_axis: one word per stereo frame, left sample in the low
// SAMPLE_WIDTH bits, right above it (feed zero on the right for mono).
// Output channel m_axis: one word per frame with the gained samples, the
// reduction in Q8.8 dB and the envelope level after the update.
// Config channel cfg: index plus data, always ready; write only while idle.
// Timing: a frame is taken in the idle state, then runs through its steps,
// among them the 16-step log2 squaring loop and the 16-step 2^f root-product
// loop, one multiplier each; no new frame is taken until its word is stored.
// s_axis_tready_o is high only while idle. The result sits in an output
// register, so a new frame is accepted while the last word waits; if the
// receiver still stalls when the next result is ready, the controller holds
// in its final step until the register is free.
// Reset: registers return to their reset values, the envelope to -60 dB,
// any word in flight is dropped.
module stereo_linked_soft_knee_compressor_top import slkc_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int DB_TABLE_DEPTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  // fields from bit 0: left_sample, right_sample
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata_i,
  // fields from bit 0: left_out, right_out, reduction_db, envelope_level
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((2*SAMPLE_WIDTH+37)/8)*8-1:0] m_axis_tdata_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [7:0]                           cfg_index_i,
  input  logic [23:0]                          cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // registers are plain flops, a write always lands
  assign cfg_ready_o = 1'b1;

  slkc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slkc_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .DB_TABLE_DEPTH (DB_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

// File: tb/sv/slkc_checker.sv
`timescale 1ns / 1ps

module slkc_checker import slkc_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int DB_TABLE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  input  logic                     s_axis_tready_i,
  input  logic [2*SAMPLE_WIDTH-1:0] s_axis_tdata_i,
  input  logic                     m_axis_tvalid_i,
  input  logic                     m_axis_tready_i,
  input  logic [2*SAMPLE_WIDTH+29:0] m_axis_tdata_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [7:0]               cfg_index_i,
  input  logic [23:0]              cfg_data_i,
  output int                       errors_o,
  output int                       pending_o
);

  // packed from the top bit down, so left_out lands in the low bits
  typedef struct packed {
    logic [14:0]             envelope;
    logic [14:0]             reduction;
    logic [SAMPLE_WIDTH-1:0] right_out;
    logic [SAMPLE_WIDTH-1:0] left_out;
  } frame_res_t;

  frame_res_t gained_q[$];

  logic [31:0] exp2_lut [DB_TABLE_DEPTH];

  logic [14:0] thr_r;
  logic [15:0] slope_r;
  logic [12:0] kw_r;
  logic [14:0] ks_r;
  logic [23:0] atk_r;
  logic [23:0] rel_r;
  logic [13:0] og_r;
  logic        auto_r;
  longint      env_r;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned rem, res, b;
    rem = n;
    res = 0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // round half away from zero of v / 2^s
  function automatic longint round_shr(input longint v, input int s);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : v;
    r   = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint level_q88(input longint unsigned m);
    int              p;
    longint unsigned x, frac, mag;
    longint          lg, db;
    if (m == 0) return FLOOR_DB;
    p = 63;
    while (m[p] == 1'b0) p--;
    x    = (p <= 30) ? (m << (30 - p)) : (m >> (p - 30));
    frac = 0;
    for (int k = 0; k < LOG_STEPS; k++) begin
      x    = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x    = x >> 1;
        frac = frac | 1;
      end
    end
    lg  = longint'(p - (SAMPLE_WIDTH - 1)) * 65536 + longint'(frac);
    mag = (lg < 0) ? longint'(-lg) : lg;
    db  = -longint'((mag * LOG2_TO_DB + (64'd1 << 23)) >> 24);
    return (db < FLOOR_DB) ? FLOOR_DB : db;
  endfunction

  function automatic longint scale_sample(input longint s, input longint unsigned mant,
                                          input int e);
    longint unsigned p, r, lim;
    int sh, ls;
    p  = ((s < 0) ? longint'(-s) : s) * mant;
    sh = 30 - e;
    if (sh > 0) begin
      r = (sh >= 63) ? 0 : ((p + (64'd1 << (sh - 1))) >> sh);
    end else begin
      ls = -sh;
      if (ls >= 62 || (p >> (62 - ls)) != 0) r = '1;
      else r = p << ls;
    end
    lim = (s < 0) ? (64'd1 << (SAMPLE_WIDTH - 1)) : ((64'd1 << (SAMPLE_WIDTH - 1)) - 1);
    if (r > lim) r = lim;
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Advances the envelope and returns the gained frame.
  function automatic frame_res_t compress_frame(input logic [2*SAMPLE_WIDTH-1:0] w);
    longint          l, r, lvl, diff, x, red, thr, slope, total, lg, t;
    longint unsigned ml, mr, k2, idx, coeff;
    int              e;
    frame_res_t      res;
    l     = longint'($signed(w[SAMPLE_WIDTH-1:0]));
    r     = longint'($signed(w[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
    ml    = (l < 0) ? longint'(-l) : l;
    mr    = (r < 0) ? longint'(-r) : r;
    lvl   = level_q88((ml > mr) ? ml : mr);
    thr   = longint'($signed(thr_r));
    slope = longint'(slope_r);
    diff  = lvl - env_r;
    coeff = (lvl > env_r) ? atk_r : rel_r;
    env_r = env_r + round_shr(diff * longint'(coeff), 24);
    if (env_r < FLOOR_DB) env_r = FLOOR_DB;
    if (env_r > 0) env_r = 0;
    x = env_r - thr;
    if (kw_r == 0 || 2 * x > longint'(kw_r)) begin
      red = (x > 0) ? round_shr(x * slope, 16) : 0;
    end else if (2 * x < -longint'(kw_r)) begin
      red = 0;
    end else begin
      k2  = 2 * x + longint'(kw_r);
      red = longint'((longint'(slope) * k2 * k2 * ks_r + (64'd1 << 37)) >> 38);
    end
    if (red > RED_MAX) red = RED_MAX;
    total = longint'($signed(og_r)) - red;
    if (auto_r) total = total - round_shr(thr * slope, 17);
    lg = round_shr(total * DB_TO_LOG2, 16);
    t  = lg + (longint'(32) << 16);
    if (t < 0) t = 0;
    e   = int'(t >> 16) - 32;
    idx = ((t & 64'hFFFF) * DB_TABLE_DEPTH) >> 16;
    if (idx >= DB_TABLE_DEPTH) idx = DB_TABLE_DEPTH - 1;
    res.left_out  = scale_sample(l, exp2_lut[idx], e);
    res.right_out = scale_sample(r, exp2_lut[idx], e);
    res.reduction = red[14:0];
    res.envelope  = env_r[14:0];
    return res;
  endfunction

  // 2^(i/D) in Q1.30 as a product of repeated square roots of two
  initial begin
    longint unsigned root [17];
    longint unsigned c, f, g;
    c = 64'd2 << 30;
    for (int k = 1; k <= LOG_STEPS; k++) begin
      c       = int_sqrt(c << 30);
      root[k] = c;
    end
    for (int i = 0; i < DB_TABLE_DEPTH; i++) begin
      f = (longint'(i) << 16) / DB_TABLE_DEPTH;
      g = 64'd1 << 30;
      for (int k = 1; k <= LOG_STEPS; k++)
        if ((f >> (16 - k)) & 1) g = (g * root[k]) >> 30;
      exp2_lut[i] = g[31:0];
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_res_t want, got;
    if (!rst_ni) begin
      thr_r   = RST_THRESHOLD;
      slope_r = RST_SLOPE;
      kw_r    = RST_KNEE_W;
      ks_r    = RST_KNEE_S;
      atk_r   = RST_ATTACK;
      rel_r   = RST_RELEASE;
      og_r    = '0;
      auto_r  = 1'b0;
      env_r   = FLOOR_DB;
      gained_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_THRESHOLD: thr_r   = cfg_data_i[14:0];
          REG_SLOPE:     slope_r = cfg_data_i[15:0];
          REG_KNEE_W:    kw_r    = cfg_data_i[12:0];
          REG_KNEE_S:    ks_r    = cfg_data_i[14:0];
          REG_ATTACK:    atk_r   = cfg_data_i;
          REG_RELEASE:   rel_r   = cfg_data_i;
          REG_OUT_GAIN:  og_r    = cfg_data_i[13:0];
          REG_AUTO_GAIN: auto_r  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) gained_q.push_back(compress_frame(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[2*SAMPLE_WIDTH+29:0];
        if (gained_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors_o++;
        end else begin
          want = gained_q.pop_front();
          if (got.left_out !== want.left_out) begin
            $display("%0t: left_out exp %h got %h", $time, want.left_out, got.left_out);
            errors_o++;
          end
          if (got.right_out !== want.right_out) begin
            $display("%0t: right_out exp %h got %h", $time, want.right_out, got.right_out);
            errors_o++;
          end
          if (got.reduction !== want.reduction) begin
            $display("%0t: reduction exp %h got %h", $time, want.reduction, got.reduction);
            errors_o++;
          end
          if (got.envelope !== want.envelope) begin
            $display("%0t: envelope exp %h got %h", $time, want.envelope, got.envelope);
            errors_o++;
          end
        end
      end
      pending_o = gained_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import slkc_pkg::*;;

  localparam int SW        = 24;
  localparam int IN_BITS   = ((2*SW+7)/8)*8;
  localparam int OUT_BITS  = ((2*SW+37)/8)*8;
  localparam int DRAIN     = 120;
  localparam int MAX_CYCLE = 3000000;
  localparam int RAND_PER_PHASE = 250;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [IN_BITS-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_index_i = '0;
  logic [23:0]         cfg_data_i = '0;

  int errors;
  int pending;
  int cycles = 0;
  int send_idle = 0;      // percent of cycles the sender holds off
  int recv_idle = 0;      // percent of cycles the receiver stalls

  stereo_linked_soft_knee_compressor_top #(
    .SAMPLE_WIDTH  (SW),
    .DB_TABLE_DEPTH(1024)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // left_sample, right_sample
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // left_out, right_out, reduction_db, envelope_level
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  slkc_checker #(
    .SAMPLE_WIDTH  (SW),
    .DB_TABLE_DEPTH(1024)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i[2*SW-1:0]),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o[2*SW+29:0]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver back-pressure, updated on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Drive on the falling edge; ready is stable there, so the word is taken
  // at the next rising edge whenever it reads high.
  task automatic cfg_write(input logic [7:0] idx, input logic [23:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_frame(input logic [SW-1:0] left, input logic [SW-1:0] right);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {right, left};
    while (!s_axis_tready_o) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // every expected word back, then room for a frame still in the pipe
  task automatic drain_out();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic load_regs(input logic [14:0] thr, input logic [15:0] slope,
                           input logic [12:0] kw, input logic [14:0] ks,
                           input logic [23:0] atk, input logic [23:0] rel,
                           input logic [13:0] og, input logic auto_on);
    cfg_write(REG_THRESHOLD, {9'd0, thr});
    cfg_write(REG_SLOPE,     {8'd0, slope});
    cfg_write(REG_KNEE_W,    {11'd0, kw});
    cfg_write(REG_KNEE_S,    {9'd0, ks});
    cfg_write(REG_ATTACK,    atk);
    cfg_write(REG_RELEASE,   rel);
    cfg_write(REG_OUT_GAIN,  {10'd0, og});
    cfg_write(REG_AUTO_GAIN, {23'd0, auto_on});
  endtask

  // random magnitude spread over the whole dB range
  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    v = SW'($urandom);
    case ($urandom_range(9))
      0:       v = 24'h800000;
      1:       v = 24'h7FFFFF;
      2:       v = '0;
      3, 4:    ;
      default: v = $signed(v) >>> $urandom_range(1, 23);
    endcase
    return v;
  endfunction

  initial begin
    logic [SW-1:0] burst;
    int            run_len;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full scale, most negative, mono, silence at reset settings
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h800000, 24'h000000);
    send_frame(24'h000000, 24'h800000);
    send_frame(24'h800000, 24'h800000);
    send_frame(24'h7FFFFF, 24'hFFFFFF);
    send_frame(24'h000001, 24'h000000);
    send_frame(24'hFFFFFF, 24'h000001);
    send_frame(24'h123456, 24'h000000);
    drain_out();   // sender holds until every word is back

    // hard knee, frozen envelope, mismatched knee scale, bogus indexes
    load_regs(15'h0000, 16'd62259, 13'd0, 15'd20480, 24'd0, 24'd0, 14'd6144, 1'b1);
    cfg_write(8'd8, 24'hFFFFFF);
    cfg_write(8'hFF, 24'h123456);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h000010, 24'h000000);
    drain_out();

    // positive threshold with auto gain, instant attack and release
    load_regs(15'h3FFF, 16'hFFFF, 13'h1FFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF,
              14'h2000, 1'b1);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h000100, 24'h000000);
    send_frame(24'h800000, 24'h400000);
    send_frame(24'h000000, 24'h000000);
    drain_out();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle = 14;
        recv_idle = 85;
      end else if (ph < 4) begin
        send_idle = 85;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: load_regs(RST_THRESHOLD, RST_SLOPE, RST_KNEE_W, RST_KNEE_S,
                     RST_ATTACK, RST_RELEASE, 14'd0, 1'b0);
        1: load_regs(15'h0000, 16'd62259, 13'd5120, 15'd20480, 24'hFFFFFF,
                     24'hFFFFFF, 14'd6144, 1'b1);
        2: load_regs(15'h4400, 16'd0, 13'd0, 15'd0, 24'd0, 24'd0, 14'h3400, 1'b0);
        3: load_regs(15'h7000, 16'd40000, 13'd2048, 15'd512, 24'd2000000,
                     24'd200000, 14'd1000, 1'b1);
        default: load_regs(15'($urandom), 16'($urandom), 13'($urandom), 15'($urandom),
                           24'($urandom), 24'($urandom), 14'($urandom), 1'($urandom));
      endcase
      // bursts of steady level so the envelope climbs and falls
      for (int n = 0; n < RAND_PER_PHASE; ) begin
        burst   = rand_sample();
        run_len = $urandom_range(1, 20);
        for (int j = 0; j < run_len && n < RAND_PER_PHASE; j++, n++) begin
          if ($urandom_range(3) == 0) send_frame(rand_sample(), rand_sample());
          else if ($urandom_range(3) == 0) send_frame(burst ^ SW'($urandom_range(255)), '0);
          else send_frame(($urandom_range(1)) ? burst : -burst, burst >>> $urandom_range(3));
        end
      end
      drain_out();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
